@@ hw/rtl/ppbb_pkg.sv @@
// shared types, widths and codes for the ping-pong byte buffer
package ppbb_pkg;

  localparam int BANK_BYTES_DEF = 64;

  localparam int OP_W   = 3;
  localparam int OFS_W  = 6;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int CNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE      = 3'd0,
    OP_STORE        = 3'd1,
    OP_FINISH_WRITE = 3'd2,
    OP_LOAD         = 3'd3,
    OP_FINISH_READ  = 3'd4,
    OP_CLEAR        = 3'd5
  } op_t;

  typedef enum logic {
    ST_IDLE    = 1'b0,
    ST_RESPOND = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } ctrl_cmd_t;

endpackage

@@ hw/rtl/ppbb_if.sv @@
// request and response channel interfaces
interface ppbb_req_if;
  logic                         valid;
  logic                         ready;
  logic [ppbb_pkg::OP_W-1:0]    op;
  logic [ppbb_pkg::OFS_W-1:0]   offset;
  logic [ppbb_pkg::BYTE_W-1:0]  value;
  logic [ppbb_pkg::LEN_W-1:0]   length;

  modport source(output valid, op, offset, value, length, input ready);
  modport sink(input valid, op, offset, value, length, output ready);
endinterface

interface ppbb_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [ppbb_pkg::BYTE_W-1:0]  read_value;
  logic [ppbb_pkg::CNT_W-1:0]   write_room;
  logic [ppbb_pkg::CNT_W-1:0]   read_left;
  logic                         clamped;

  modport source(output valid, ok, read_value, write_room, read_left, clamped, input ready);
  modport sink(input valid, ok, read_value, write_room, read_left, clamped, output ready);
endinterface

@@ hw/rtl/ppbb_ctrl.sv @@
// handshake controller: takes one request, then holds its response until taken
module ppbb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output ppbb_pkg::ctrl_cmd_t cmd
);

  ppbb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppbb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.exec   = 1'b0;
    case (state)
      ppbb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec   = 1'b1;
          state_next = ppbb_pkg::ST_RESPOND;
        end
      end
      ppbb_pkg::ST_RESPOND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ppbb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppbb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/ppbb_datapath.sv @@
// counters, bank store and response registers of the ping-pong byte buffer
module ppbb_datapath #(
  parameter int BANK_BYTES = ppbb_pkg::BANK_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppbb_pkg::ctrl_cmd_t           cmd,
  input  logic [ppbb_pkg::OP_W-1:0]     op,
  input  logic [ppbb_pkg::OFS_W-1:0]    offset,
  input  logic [ppbb_pkg::BYTE_W-1:0]   value,
  input  logic [ppbb_pkg::LEN_W-1:0]    length,
  output logic                          ok,
  output logic [ppbb_pkg::BYTE_W-1:0]   read_value,
  output logic [ppbb_pkg::CNT_W-1:0]    write_room,
  output logic [ppbb_pkg::CNT_W-1:0]    read_left,
  output logic                          clamped
);

  localparam int CW = $clog2(BANK_BYTES + 1);
  localparam int AW = $clog2(BANK_BYTES);
  localparam int XW = ((CW > ppbb_pkg::LEN_W) ? CW : ppbb_pkg::LEN_W) + 1;

  logic [CW-1:0] fill_level, fill_level_next;
  logic [CW-1:0] drain_level, drain_level_next;
  logic [CW-1:0] drain_pointer, drain_pointer_next;
  logic          fill_bank_select, fill_bank_select_next;
  logic          write_in_progress, write_in_progress_next;

  logic [ppbb_pkg::BYTE_W-1:0] bank_store [2][BANK_BYTES];
  logic [ppbb_pkg::BYTE_W-1:0] mem_rdata;

  // response registers
  logic                        ok_r, clamped_r, load_hit;
  logic [ppbb_pkg::CNT_W-1:0]  write_room_r, read_left_r;

  logic                        ok_c, clamped_c, do_store, do_load;
  logic [XW-1:0]               store_pos, load_pos, avail, take, new_count;
  logic [XW-1:0]               room_x, left_x;
  ppbb_pkg::op_t               op_dec;

  always_comb begin
    op_dec                 = ppbb_pkg::op_t'(op);
    fill_level_next        = fill_level;
    drain_level_next       = drain_level;
    drain_pointer_next     = drain_pointer;
    fill_bank_select_next  = fill_bank_select;
    write_in_progress_next = write_in_progress;
    ok_c      = 1'b0;
    clamped_c = 1'b0;
    do_store  = 1'b0;
    do_load   = 1'b0;
    avail     = '0;
    take      = '0;
    new_count = '0;
    store_pos = XW'(fill_level) + XW'(offset);
    load_pos  = XW'(drain_pointer) + XW'(offset);
    case (op_dec)
      ppbb_pkg::OP_RESERVE: begin
        if (XW'(fill_level) < XW'(BANK_BYTES)) begin
          write_in_progress_next = 1'b1;
          ok_c = 1'b1;
        end
      end
      ppbb_pkg::OP_STORE: begin
        if (store_pos < XW'(BANK_BYTES)) begin
          do_store = 1'b1;
          ok_c = 1'b1;
        end
      end
      ppbb_pkg::OP_FINISH_WRITE: begin
        write_in_progress_next = 1'b0;
        avail = XW'(BANK_BYTES) - XW'(fill_level);
        if (XW'(length) > avail) begin
          take = avail;
          clamped_c = 1'b1;
        end else begin
          take = XW'(length);
          ok_c = 1'b1;
        end
        new_count = XW'(fill_level) + take;
        fill_level_next = new_count[CW-1:0];
        // full fill bank: swap if the drain side is empty (write already ended)
        if (new_count == XW'(BANK_BYTES) && drain_pointer == drain_level) begin
          drain_level_next      = new_count[CW-1:0];
          drain_pointer_next    = '0;
          fill_level_next       = '0;
          fill_bank_select_next = ~fill_bank_select;
        end
      end
      ppbb_pkg::OP_LOAD: begin
        if (load_pos < XW'(drain_level)) begin
          do_load = 1'b1;
          ok_c = 1'b1;
        end
      end
      ppbb_pkg::OP_FINISH_READ: begin
        avail = XW'(drain_level) - XW'(drain_pointer);
        if (XW'(length) > avail) begin
          take = avail;
          clamped_c = 1'b1;
        end else begin
          take = XW'(length);
          ok_c = 1'b1;
        end
        new_count = XW'(drain_pointer) + take;
        drain_pointer_next = new_count[CW-1:0];
        if (new_count == XW'(drain_level) && !write_in_progress && fill_level != '0) begin
          drain_level_next      = fill_level;
          drain_pointer_next    = '0;
          fill_level_next       = '0;
          fill_bank_select_next = ~fill_bank_select;
        end
      end
      ppbb_pkg::OP_CLEAR: begin
        fill_level_next        = '0;
        drain_level_next       = '0;
        drain_pointer_next     = '0;
        fill_bank_select_next  = 1'b0;
        write_in_progress_next = 1'b0;
        ok_c = 1'b1;
      end
      default: begin
      end
    endcase
    room_x = XW'(BANK_BYTES) - XW'(fill_level_next);
    left_x = XW'(drain_level_next) - XW'(drain_pointer_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level        <= '0;
      drain_level       <= '0;
      drain_pointer     <= '0;
      fill_bank_select  <= 1'b0;
      write_in_progress <= 1'b0;
    end else if (cmd.exec) begin
      fill_level        <= fill_level_next;
      drain_level       <= drain_level_next;
      drain_pointer     <= drain_pointer_next;
      fill_bank_select  <= fill_bank_select_next;
      write_in_progress <= write_in_progress_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      ok_r         <= ok_c;
      clamped_r    <= clamped_c;
      load_hit     <= do_load;
      write_room_r <= room_x[ppbb_pkg::CNT_W-1:0];
      read_left_r  <= left_x[ppbb_pkg::CNT_W-1:0];
    end
  end

  // bank store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && do_store) begin
      bank_store[fill_bank_select][store_pos[AW-1:0]] <= value;
    end
    if (cmd.exec && do_load) begin
      mem_rdata <= bank_store[~fill_bank_select][load_pos[AW-1:0]];
    end
  end

  assign ok         = ok_r;
  assign clamped    = clamped_r;
  assign read_value = load_hit ? mem_rdata : '0;
  assign write_room = write_room_r;
  assign read_left  = read_left_r;

endmodule

@@ hw/rtl/ping_pong_byte_buffer.sv @@
// ping-pong byte buffer top level
// latency: the response is presented in the cycle after its request is taken
// flow: the controller takes no new request while a response is still waiting
// reset: clears both bank levels, the read pointer, bank select, the write flag
//   and the handshake state; stored bytes are not cleared
module ping_pong_byte_buffer #(
  parameter int BANK_BYTES = ppbb_pkg::BANK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ppbb_req_if.sink    req,
  ppbb_rsp_if.source  rsp
);

  ppbb_pkg::ctrl_cmd_t cmd;

  ppbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  ppbb_datapath #(
    .BANK_BYTES (BANK_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (req.op),
    .offset     (req.offset),
    .value      (req.value),
    .length     (req.length),
    .ok         (rsp.ok),
    .read_value (rsp.read_value),
    .write_room (rsp.write_room),
    .read_left  (rsp.read_left),
    .clamped    (rsp.clamped)
  );

  // every request gets its response in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> rsp.valid)
  else $error("response missing after request");

  // no new request while a response is pending
  assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
  else $error("request taken while response pending");

  // a clamped finish never reports success
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.clamped) |-> !rsp.ok)
  else $error("clamped response flagged ok");

  // a full fill bank implies data waiting in the drain bank
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (BANK_BYTES < (1 << ppbb_pkg::CNT_W)) && rsp.write_room == '0)
      |-> (rsp.read_left != '0))
  else $error("fill bank full with drain bank empty");

endmodule
